>>> src/sdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_pkg: shared types for the sorted descending insert table
// Request codes, status codes and the result record.
// ----------------------------------------------------------------------------
package sdi_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OpInsert = 2'd0,
    OpRead   = 2'd1,
    OpClear  = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ValueW-1:0] read_data;
    logic [PosW-1:0]          position;
    logic [CountW-1:0]        count;
    status_e                  status;
  } res_t;

endpackage

>>> src/sdi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_ram: generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
module sdi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sdi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdi_ctrl: request sequencer with shared compare unit
// On insert, walks the list from its tail, moving each entry not greater
// than the new value down one slot, then stores the value in the freed slot.
// ----------------------------------------------------------------------------
module sdi_ctrl #(
  parameter int unsigned Depth = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  input  logic [sdi_pkg::OpW-1:0]           req_op_i,
  input  logic signed [sdi_pkg::ValueW-1:0] req_value_i,
  input  logic [sdi_pkg::IndexW-1:0]        req_index_i,
  output logic                              busy_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output sdi_pkg::res_t                     res_o,
  output logic                              ram_we_o,
  output logic [$clog2(Depth)-1:0]          ram_addr_o,
  output logic [sdi_pkg::ValueW-1:0]        ram_wdata_o,
  input  logic [sdi_pkg::ValueW-1:0]        ram_rdata_i
);

  import sdi_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned CmpW  = (CntW > IndexW) ? CntW : IndexW;

  typedef enum logic [2:0] {
    SIdle,
    SRead,
    SComp,
    SPut,
    SRdWait,
    SDone
  } state_e;

  state_e                   state_q;
  logic [CntW-1:0]          used_q;
  logic [AddrW-1:0]         ptr_q;
  logic signed [ValueW-1:0] val_q;
  logic signed [ValueW-1:0] rdata_q;
  logic [PosW-1:0]          pos_q;
  status_e                  status_q;

  logic full;
  logic idx_ok;
  logic le;

  assign full   = (used_q == CntW'(Depth));
  assign idx_ok = (CmpW'(req_index_i) < CmpW'(used_q));
  assign le     = ($signed(ram_rdata_i) <= val_q);

  always_comb begin
    ram_we_o    = 1'b0;
    ram_addr_o  = ptr_q;
    ram_wdata_o = val_q;
    case (state_q)
      SIdle: begin
        ram_addr_o = AddrW'(req_index_i);
      end
      SComp: begin
        ram_we_o    = le;
        ram_addr_o  = ptr_q + AddrW'(1);
        ram_wdata_o = ram_rdata_i;
      end
      SPut: begin
        ram_we_o = 1'b1;
      end
      default: begin
        ram_addr_o = ptr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      used_q   <= '0;
      ptr_q    <= '0;
      val_q    <= '0;
      rdata_q  <= '0;
      pos_q    <= '0;
      status_q <= StOk;
    end else begin
      case (state_q)
        SIdle: begin
          if (req_valid_i) begin
            val_q    <= req_value_i;
            rdata_q  <= '0;
            pos_q    <= '0;
            status_q <= StOk;
            case (req_op_i)
              OpInsert: begin
                if (full) begin
                  status_q <= StFull;
                  state_q  <= SDone;
                end else if (used_q == '0) begin
                  ptr_q   <= '0;
                  state_q <= SPut;
                end else begin
                  ptr_q   <= AddrW'(used_q - CntW'(1));
                  state_q <= SRead;
                end
              end
              OpRead: begin
                if (idx_ok) begin
                  state_q <= SRdWait;
                end else begin
                  status_q <= StRange;
                  state_q  <= SDone;
                end
              end
              OpClear: begin
                used_q  <= '0;
                state_q <= SDone;
              end
              default: begin
                state_q <= SDone;
              end
            endcase
          end
        end
        SRead: begin
          state_q <= SComp;
        end
        SComp: begin
          if (le) begin
            if (ptr_q == '0) begin
              state_q <= SPut;
            end else begin
              ptr_q   <= ptr_q - AddrW'(1);
              state_q <= SRead;
            end
          end else begin
            ptr_q   <= ptr_q + AddrW'(1);
            state_q <= SPut;
          end
        end
        SPut: begin
          used_q  <= used_q + CntW'(1);
          pos_q   <= PosW'(ptr_q);
          state_q <= SDone;
        end
        SRdWait: begin
          rdata_q <= $signed(ram_rdata_i);
          state_q <= SDone;
        end
        SDone: begin
          if (res_ready_i) begin
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != SIdle);
  assign res_valid_o = (state_q == SDone);

  always_comb begin
    res_o.read_data = rdata_q;
    res_o.position  = pos_q;
    res_o.count     = CountW'(used_q);
    res_o.status    = status_q;
  end

endmodule

>>> src/sorted_descending_insert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_descending_insert: descending sorted table with insert/read/clear
// Clear, full insert, out-of-range read and unused op skip the RAM; a good
// read waits for the registered RAM data; an insert that compares c entries
// (0 <= c < DEPTH) passes through a read and a compare state for each, then
// a write state. One request at a time: the next transfer is taken in the
// cycle after the result moves to the output register, since the compare unit
// and the single RAM port are shared by every step of the tail-to-head scan.
// Reset clears the entry count; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
module sorted_descending_insert #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               stall_o,
  input  logic [sdi_pkg::OpW-1:0]            op_i,
  input  logic signed [sdi_pkg::ValueW-1:0]  value_i,
  input  logic [sdi_pkg::IndexW-1:0]         index_i,
  output logic                               valid_o,
  input  logic                               stall_i,
  output logic signed [sdi_pkg::ValueW-1:0]  read_data_o,
  output logic [sdi_pkg::PosW-1:0]           position_o,
  output logic [sdi_pkg::CountW-1:0]         count_o,
  output logic [sdi_pkg::StatusW-1:0]        status_o
);

  import sdi_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);

  logic               busy;
  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               ram_we;
  logic [AddrW-1:0]   ram_addr;
  logic [ValueW-1:0]  ram_wdata;
  logic [ValueW-1:0]  ram_rdata;

  logic out_valid_q;
  res_t out_q;

  sdi_ctrl #(
    .Depth(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (valid_i),
    .req_op_i    (op_i),
    .req_value_i (value_i),
    .req_index_i (index_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  sdi_ram #(
    .Width(ValueW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign stall_o   = busy;
  assign res_ready = !out_valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign valid_o     = out_valid_q;
  assign read_data_o = out_q.read_data;
  assign position_o  = out_q.position;
  assign count_o     = out_q.count;
  assign status_o    = out_q.status;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o)
    else $error("sequencer idle right after a request transfer");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == StFull |-> count_o == CountW'(DEPTH))
    else $error("full status without a full table");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == StRange |-> read_data_o == '0 && position_o == '0)
    else $error("out-of-range read returned nonzero fields");

  a_result_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> busy)
    else $error("result offered while sequencer idle");

endmodule
